// ===== rtl/ipn_endpoint_id_parser_top_macros.svh =====
// Assertion macros used by the endpoint-ID parser core.
`ifndef IPN_ENDPOINT_ID_PARSER_TOP_MACROS_SVH
`define IPN_ENDPOINT_ID_PARSER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IPN_EID_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define IPN_EID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ipn_eid_pkg.sv =====
// Types, constants and helpers for the endpoint-ID parser.
`timescale 1ns / 1ps
`default_nettype none

package ipn_eid_pkg;

    localparam int MAX_LEN = 128;
    localparam int POS_W   = $clog2(MAX_LEN + 2);

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LEN);
    localparam logic [POS_W-1:0] MIN_POS = POS_W'(7);

    // status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_LENGTH  = 3'd1;
    localparam logic [2:0] ST_BAD_PREFIX  = 3'd2;
    localparam logic [2:0] ST_NO_DOT      = 3'd3;
    localparam logic [2:0] ST_BAD_NODE    = 3'd4;
    localparam logic [2:0] ST_BAD_SERVICE = 3'd5;

    // parse phases
    localparam logic [2:0] PH_PREFIX   = 3'd0;
    localparam logic [2:0] PH_NODE     = 3'd1;
    localparam logic [2:0] PH_SERVICE  = 3'd2;
    localparam logic [2:0] PH_NUL_EARLY = 3'd3;
    localparam logic [2:0] PH_SERV_END = 3'd4;

    // field sub-states
    localparam logic [1:0] SUB_BLANKS  = 2'd0;
    localparam logic [1:0] SUB_SIGN    = 2'd1;
    localparam logic [1:0] SUB_DIGITS  = 2'd2;
    localparam logic [1:0] SUB_STOPPED = 2'd3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
    } chr_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] node_num;
        logic [63:0] serv_num;
    } res_item_t;

    typedef struct packed {
        logic       bad;
        logic       neg;
        logic [1:0] sub;
    } field_flags_t;

    // snapshot of the parse state at the last byte of a string
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             prefix_failed;
        logic [2:0]       phase;
        field_flags_t     node_f;
        field_flags_t     serv_f;
        logic [63:0]      node_acc;
        logic [63:0]      serv_acc;
    } fin_t;

    function automatic logic [7:0] prefix_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = 8'h69;  // i
            2'd1:    ch = 8'h70;  // p
            2'd2:    ch = 8'h6E;  // n
            default: ch = 8'h3A;  // :
        endcase
        return ch;
    endfunction

    function automatic logic is_blank(input logic [7:0] ch);
        return (ch == CH_SPACE) || (ch inside {[8'h09:8'h0D]});
    endfunction

    function automatic field_flags_t field_close(input field_flags_t f);
        field_flags_t r;
        r = f;
        if (f.sub == SUB_BLANKS || f.sub == SUB_SIGN) begin
            r.bad = 1'b1;
        end
        r.sub = SUB_STOPPED;
        return r;
    endfunction

    function automatic logic field_ok(input field_flags_t f);
        return !f.bad && (f.sub == SUB_DIGITS || f.sub == SUB_STOPPED);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ipn_eid_field.sv =====
// One byte step of a strtoul-style decimal field: flags and accumulator.
`timescale 1ns / 1ps
`default_nettype none

module ipn_eid_field (
    input  wire logic [7:0]                  character,
    input  wire ipn_eid_pkg::field_flags_t   flags,
    input  wire logic [63:0]                 acc,
    output ipn_eid_pkg::field_flags_t        flags_upd,
    output logic [63:0]                      acc_upd
);
    import ipn_eid_pkg::*;

    logic [67:0] acc_ext;
    logic [67:0] acc_x10;
    logic        is_digit;
    logic        ovf;

    // acc * 10 + digit, with four guard bits to catch overflow
    assign acc_ext  = {4'b0, acc};
    assign acc_x10  = (acc_ext << 3) + (acc_ext << 1) + {64'b0, character[3:0]};
    assign ovf      = |acc_x10[67:64];
    assign is_digit = character inside {[8'h30:8'h39]};

    always_comb
    begin
        flags_upd = flags;
        acc_upd   = acc;
        if (flags.sub != SUB_STOPPED)
        begin
            if (is_digit)
            begin
                if (!flags.bad)
                begin
                    if (ovf)
                    begin
                        flags_upd.bad = 1'b1;
                    end
                    else
                    begin
                        acc_upd = acc_x10[63:0];
                    end
                end
                flags_upd.sub = SUB_DIGITS;
            end
            else if (flags.sub == SUB_BLANKS && is_blank(character))
            begin
                flags_upd = flags;
            end
            else if (flags.sub == SUB_BLANKS &&
                     (character == CH_PLUS || character == CH_MINUS))
            begin
                flags_upd.sub = SUB_SIGN;
                if (character == CH_MINUS)
                begin
                    flags_upd.neg = 1'b1;
                end
            end
            else
            begin
                if (flags.sub == SUB_BLANKS || flags.sub == SUB_SIGN)
                begin
                    flags_upd.bad = 1'b1;
                end
                flags_upd.sub = SUB_STOPPED;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ipn_eid_core.sv =====
// Per-byte parse state and the end-of-string snapshot register.
`timescale 1ns / 1ps
`default_nettype none
`include "ipn_endpoint_id_parser_top_macros.svh"

module ipn_eid_core (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    item_valid,
    input  wire ipn_eid_pkg::chr_item_t  item,
    output logic                         take,
    output logic                         fin_valid,
    output ipn_eid_pkg::fin_t            fin,
    input  wire logic                    fin_move
);
    import ipn_eid_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next, pos_upd;
    logic             pf_reg, pf_next, pf_upd;
    logic [2:0]       phase_reg, phase_next, phase_upd;
    field_flags_t     node_f_reg, node_f_next, node_f_upd;
    field_flags_t     serv_f_reg, serv_f_next, serv_f_upd;
    logic [63:0]      node_acc_reg, node_acc_next, node_acc_upd;
    logic [63:0]      serv_acc_reg, serv_acc_next, serv_acc_upd;
    logic             fin_valid_reg, fin_valid_next;
    fin_t             fin_reg, fin_next;

    logic             use_serv;
    field_flags_t     unit_f_in, unit_f_out;
    logic [63:0]      unit_acc_in, unit_acc_out;
    logic [7:0]       ch;

    assign ch          = item.character;
    assign use_serv    = (phase_reg == PH_SERVICE);
    assign unit_f_in   = use_serv ? serv_f_reg : node_f_reg;
    assign unit_acc_in = use_serv ? serv_acc_reg : node_acc_reg;

    // one field unit, shared by the node and service fields
    ipn_eid_field u_field (
        .character (ch),
        .flags     (unit_f_in),
        .acc       (unit_acc_in),
        .flags_upd (unit_f_out),
        .acc_upd   (unit_acc_out)
    );

    // the last byte needs the snapshot slot
    assign take = item_valid && (!item.last_char || !fin_valid_reg || fin_move);

    always_comb
    begin
        pos_upd      = pos_reg;
        pf_upd       = pf_reg;
        phase_upd    = phase_reg;
        node_f_upd   = node_f_reg;
        serv_f_upd   = serv_f_reg;
        node_acc_upd = node_acc_reg;
        serv_acc_upd = serv_acc_reg;
        if (pos_reg < MAX_POS)
        begin
            case (phase_reg)
                PH_PREFIX:
                begin
                    if (ch != prefix_char(pos_reg[1:0]))
                    begin
                        pf_upd = 1'b1;
                    end
                    if (pos_reg >= POS_W'(3))
                    begin
                        phase_upd = PH_NODE;
                    end
                end
                PH_NODE:
                begin
                    if (ch == CH_DOT)
                    begin
                        node_f_upd = field_close(node_f_reg);
                        phase_upd  = PH_SERVICE;
                    end
                    else if (ch == CH_NUL)
                    begin
                        phase_upd = PH_NUL_EARLY;
                    end
                    else
                    begin
                        node_f_upd   = unit_f_out;
                        node_acc_upd = unit_acc_out;
                    end
                end
                PH_SERVICE:
                begin
                    if (ch == CH_NUL)
                    begin
                        serv_f_upd = field_close(serv_f_reg);
                        phase_upd  = PH_SERV_END;
                    end
                    else
                    begin
                        serv_f_upd   = unit_f_out;
                        serv_acc_upd = unit_acc_out;
                    end
                end
                default:
                begin
                    phase_upd = phase_reg;
                end
            endcase
        end
        // saturates one past the limit
        if (pos_reg <= MAX_POS)
        begin
            pos_upd = pos_reg + POS_W'(1);
        end
    end

    always_comb
    begin
        pos_next       = pos_reg;
        pf_next        = pf_reg;
        phase_next     = phase_reg;
        node_f_next    = node_f_reg;
        serv_f_next    = serv_f_reg;
        node_acc_next  = node_acc_reg;
        serv_acc_next  = serv_acc_reg;
        fin_next       = fin_reg;
        fin_valid_next = fin_valid_reg && !fin_move;
        if (take)
        begin
            if (item.last_char)
            begin
                fin_next.pos           = pos_upd;
                fin_next.prefix_failed = pf_upd;
                fin_next.phase         = phase_upd;
                fin_next.node_f        = node_f_upd;
                fin_next.serv_f        = serv_f_upd;
                fin_next.node_acc      = node_acc_upd;
                fin_next.serv_acc      = serv_acc_upd;
                fin_valid_next         = 1'b1;
                pos_next               = '0;
                pf_next                = 1'b0;
                phase_next             = PH_PREFIX;
                node_f_next            = '0;
                serv_f_next            = '0;
                node_acc_next          = '0;
                serv_acc_next          = '0;
            end
            else
            begin
                pos_next      = pos_upd;
                pf_next       = pf_upd;
                phase_next    = phase_upd;
                node_f_next   = node_f_upd;
                serv_f_next   = serv_f_upd;
                node_acc_next = node_acc_upd;
                serv_acc_next = serv_acc_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            pf_reg        <= 1'b0;
            phase_reg     <= PH_PREFIX;
            node_f_reg    <= '0;
            serv_f_reg    <= '0;
            node_acc_reg  <= '0;
            serv_acc_reg  <= '0;
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            pf_reg        <= pf_next;
            phase_reg     <= phase_next;
            node_f_reg    <= node_f_next;
            serv_f_reg    <= serv_f_next;
            node_acc_reg  <= node_acc_next;
            serv_acc_reg  <= serv_acc_next;
            fin_valid_reg <= fin_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fin_reg <= fin_next;
    end

    assign fin_valid = fin_valid_reg;
    assign fin       = fin_reg;

    `IPN_EID_ASSERT_NEXT(a_reset_after_last, clk, rst_n, take && item.last_char, pos_reg == '0 && phase_reg == PH_PREFIX && !pf_reg, "parse state not cleared after last byte")
    `IPN_EID_ASSERT_NOW(a_pos_bound, clk, rst_n, 1'b1, pos_reg <= MAX_POS + POS_W'(1), "byte position past saturation")
    `IPN_EID_ASSERT_NOW(a_phase_pos, clk, rst_n, phase_reg != PH_PREFIX, pos_reg >= POS_W'(4), "left prefix phase before four bytes")
    `IPN_EID_ASSERT_NEXT(a_fin_hold, clk, rst_n, fin_valid_reg && !fin_move, fin_valid_reg && $stable(fin_reg), "pending snapshot lost or changed")

endmodule

`default_nettype wire

// ===== rtl/ipn_eid_result.sv =====
// Status decision, sign application and the result output register.
`timescale 1ns / 1ps
`default_nettype none

module ipn_eid_result (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fin_valid,
    input  wire ipn_eid_pkg::fin_t  fin,
    output logic                    fin_move,
    output logic                    res_valid,
    output ipn_eid_pkg::res_item_t  res_item,
    input  wire logic               res_stall
);
    import ipn_eid_pkg::*;

    logic      res_valid_reg, res_valid_next;
    res_item_t res_reg, res_next;
    res_item_t res_calc;

    assign fin_move = !res_valid_reg || !res_stall;

    always_comb
    begin
        res_calc.status   = ST_OK;
        res_calc.node_num = '0;
        res_calc.serv_num = '0;
        if (fin.pos < MIN_POS || fin.pos > MAX_POS)
        begin
            res_calc.status = ST_BAD_LENGTH;
        end
        else if (fin.prefix_failed)
        begin
            res_calc.status = ST_BAD_PREFIX;
        end
        else if (fin.phase != PH_SERVICE && fin.phase != PH_SERV_END)
        begin
            res_calc.status = ST_NO_DOT;
        end
        else if (!field_ok(fin.node_f))
        begin
            res_calc.status = ST_BAD_NODE;
        end
        else if (!field_ok(fin.serv_f))
        begin
            res_calc.status = ST_BAD_SERVICE;
        end
        else
        begin
            // a minus sign wraps modulo 2^64
            res_calc.node_num = fin.node_f.neg ? (64'd0 - fin.node_acc) : fin.node_acc;
            res_calc.serv_num = fin.serv_f.neg ? (64'd0 - fin.serv_acc) : fin.serv_acc;
        end
    end

    always_comb
    begin
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        if (fin_move)
        begin
            res_valid_next = fin_valid;
            if (fin_valid)
            begin
                res_next = res_calc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;

endmodule

`default_nettype wire

// ===== rtl/ipn_endpoint_id_parser_top.sv =====
// Endpoint-ID parser: reads bytes, reports "ipn:node.service" per string.
// Throughput: one byte per cycle when not stalled, strings back to back, no gap.
// The result passes the input register, the parse-state snapshot and the
// status/sign output register; a stall on the output can hold it in each.
// Each byte's accumulator step is one shift-add times ten plus the digit.
// Reset (rst_n low, asynchronous) empties all stages and clears the parse state.
`timescale 1ns / 1ps
`default_nettype none

module ipn_endpoint_id_parser_top (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    chr_valid,
    output logic                         chr_stall,
    input  wire ipn_eid_pkg::chr_item_t  chr_item,
    output logic                         res_valid,
    input  wire logic                    res_stall,
    output ipn_eid_pkg::res_item_t       res_item
);
    import ipn_eid_pkg::*;

    logic      in_valid_reg, in_valid_next;
    chr_item_t in_item_reg, in_item_next;
    logic      core_take;
    logic      fin_valid;
    fin_t      fin;
    logic      fin_move;
    logic      load;

    assign chr_stall = in_valid_reg && !core_take;
    assign load      = chr_valid && !chr_stall;

    always_comb
    begin
        in_item_next  = in_item_reg;
        in_valid_next = in_valid_reg && !core_take;
        if (load)
        begin
            in_item_next  = chr_item;
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
    end

    ipn_eid_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .item       (in_item_reg),
        .take       (core_take),
        .fin_valid  (fin_valid),
        .fin        (fin),
        .fin_move   (fin_move)
    );

    ipn_eid_result u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .fin_valid (fin_valid),
        .fin       (fin),
        .fin_move  (fin_move),
        .res_valid (res_valid),
        .res_item  (res_item),
        .res_stall (res_stall)
    );

endmodule

`default_nettype wire

// ===== sim/tb_ipn_endpoint_id_parser_top.sv =====
// Self-checking testbench for the endpoint-ID parser: directed and random strings vs. a predictor.
`timescale 1ns / 1ps

module tb_ipn_endpoint_id_parser_top;

    import ipn_eid_pkg::*;

    localparam int         WDOG_LIMIT = 4000;  // well above the long receiver hold
    localparam int         LONG_HOLD  = 400;
    localparam logic [31:0] IPN_TAG   = "ipn:";
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      chr_valid = 1'b0;
    logic      chr_stall;
    chr_item_t chr_item  = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_item_t res_item;

    chr_item_t  char_q[$];         // characters waiting to be sent
    res_item_t  eid_results_q[$];  // parse results still to come out
    logic [7:0] txt_q[$];          // string under construction

    int sent_chars  = 0;
    int n_results   = 0;
    int n_errors    = 0;
    int snd_gap     = 0;
    int rcv_gap     = 0;
    int idle_cycles = 0;
    bit calm        = 1'b0;
    bit hold_req    = 1'b0;
    bit hold_done   = 1'b0;

    // parse state of the string being received
    int           pp_pos;
    bit           pp_prefix_bad;
    logic [2:0]   pp_phase;
    logic [63:0]  pp_node_acc;
    logic [63:0]  pp_serv_acc;
    field_flags_t pp_node_f;
    field_flags_t pp_serv_f;

    ipn_endpoint_id_parser_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .chr_valid (chr_valid),
        .chr_stall (chr_stall),
        .chr_item  (chr_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    always #5 clk = ~clk;

    function automatic bit ws_char(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic field_flags_t num_close(input field_flags_t f);
        field_flags_t r;
        r = f;
        if (f.sub == SUB_BLANKS || f.sub == SUB_SIGN)
        begin
            r.bad = 1'b1;
        end
        r.sub = SUB_STOPPED;
        return r;
    endfunction

    function automatic bit num_ok(input field_flags_t f);
        return !f.bad && (f.sub == SUB_DIGITS || f.sub == SUB_STOPPED);
    endfunction

    // strtoul-style decimal field, one character at a time
    task automatic num_feed(inout field_flags_t f, inout logic [63:0] acc,
                            input logic [7:0] c);
        logic [63:0] d;
        d = 64'(c) - 64'(CH_ZERO);
        if (f.sub != SUB_STOPPED)
        begin
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                if (!f.bad)
                begin
                    if (acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10)
                        f.bad = 1'b1;
                    else
                        acc = acc * 64'd10 + d;
                end
                f.sub = SUB_DIGITS;
            end
            else if (f.sub == SUB_BLANKS && (c == CH_PLUS || c == CH_MINUS))
            begin
                f.sub = SUB_SIGN;
                if (c == CH_MINUS)
                    f.neg = 1'b1;
            end
            else if (!(f.sub == SUB_BLANKS && ws_char(c)))
            begin
                if (f.sub == SUB_BLANKS || f.sub == SUB_SIGN)
                    f.bad = 1'b1;
                f.sub = SUB_STOPPED;
            end
        end
    endtask

    task automatic clear_parse();
        pp_pos        = 0;
        pp_prefix_bad = 1'b0;
        pp_phase      = PH_PREFIX;
        pp_node_acc   = '0;
        pp_serv_acc   = '0;
        pp_node_f     = '0;
        pp_serv_f     = '0;
    endtask

    task automatic parse_char(input chr_item_t it);
        res_item_t    r;
        field_flags_t sf;
        logic [7:0]   c;
        c = it.character;
        if (pp_pos < MAX_LEN)
        begin
            case (pp_phase)
                PH_PREFIX:
                begin
                    if (c != IPN_TAG[31 - 8 * (pp_pos % 4) -: 8])
                        pp_prefix_bad = 1'b1;
                    if (pp_pos >= 3)
                        pp_phase = PH_NODE;
                end
                PH_NODE:
                begin
                    if (c == CH_DOT)
                    begin
                        pp_node_f = num_close(pp_node_f);
                        pp_phase  = PH_SERVICE;
                    end
                    else if (c == CH_NUL)
                        pp_phase = PH_NUL_EARLY;
                    else
                        num_feed(pp_node_f, pp_node_acc, c);
                end
                PH_SERVICE:
                begin
                    if (c == CH_NUL)
                    begin
                        pp_serv_f = num_close(pp_serv_f);
                        pp_phase  = PH_SERV_END;
                    end
                    else
                        num_feed(pp_serv_f, pp_serv_acc, c);
                end
                default: ;
            endcase
        end
        if (pp_pos <= MAX_LEN)
            pp_pos++;

        if (it.last_char)
        begin
            r  = '0;
            sf = num_close(pp_serv_f);
            if (pp_pos < 7 || pp_pos > MAX_LEN)
                r.status = ST_BAD_LENGTH;
            else if (pp_prefix_bad)
                r.status = ST_BAD_PREFIX;
            else if (pp_phase != PH_SERVICE && pp_phase != PH_SERV_END)
                r.status = ST_NO_DOT;
            else if (!num_ok(pp_node_f))
                r.status = ST_BAD_NODE;
            else if (!num_ok(sf))
                r.status = ST_BAD_SERVICE;
            else
            begin
                r.status   = ST_OK;
                r.node_num = pp_node_f.neg ? 64'd0 - pp_node_acc : pp_node_acc;
                r.serv_num = sf.neg ? 64'd0 - pp_serv_acc : pp_serv_acc;
            end
            eid_results_q.push_back(r);
            clear_parse();
        end
    endtask

    task automatic report_mismatch(input string what);
        n_errors++;
        $display("ERROR result %0d @%0t: %s", n_results, $realtime, what);
    endtask

    task automatic check_result(input res_item_t got);
        res_item_t want;
        if (eid_results_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result, status %0d", got.status));
        end
        else
        begin
            want = eid_results_q.pop_front();
            if (got.status !== want.status || got.node_num !== want.node_num ||
                got.serv_num !== want.serv_num)
                report_mismatch($sformatf("got %0d/%0d/%0d, expected %0d/%0d/%0d",
                    got.status, got.node_num, got.serv_num,
                    want.status, want.node_num, want.serv_num));
        end
        n_results++;
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chr_valid <= 1'b0;
            chr_item  <= '0;
            snd_gap = 0;
        end
        else
        begin
            if (chr_valid && !chr_stall)
                parse_char(chr_item);
            if (!chr_valid || !chr_stall)
            begin
                if (snd_gap > 0)
                begin
                    snd_gap--;
                    chr_valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 19) == 0)
                begin
                    snd_gap = $urandom_range(1, 17) - 1;
                    chr_valid <= 1'b0;
                end
                else if (char_q.size() != 0)
                begin
                    chr_item  <= char_q.pop_front();
                    chr_valid <= 1'b1;
                end
                else
                    chr_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            rcv_gap = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
                check_result(res_item);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                rcv_gap   = LONG_HOLD - 1;
                res_stall <= 1'b1;
            end
            else if (rcv_gap > 0)
            begin
                rcv_gap--;
                res_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 15) == 0)
            begin
                rcv_gap = $urandom_range(1, 17) - 1;
                res_stall <= 1'b1;
            end
            else
                res_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !((chr_valid && !chr_stall) || (res_valid && !res_stall)))
        begin
            idle_cycles++;
            if (idle_cycles >= WDOG_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
        else
            idle_cycles = 0;
    end

    task automatic put_byte(input logic [7:0] b);
        txt_q.push_back(b);
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            txt_q.push_back(s[i]);
    endtask

    task automatic put_fill(input logic [7:0] b, input int n);
        repeat (n) txt_q.push_back(b);
    endtask

    task automatic emit_text();
        chr_item_t it;
        for (int i = 0; i < txt_q.size(); i++)
        begin
            it.character = txt_q[i];
            it.last_char = (i == txt_q.size() - 1);
            char_q.push_back(it);
        end
        sent_chars += txt_q.size();
        txt_q.delete();
    endtask

    task automatic send_str(input string s);
        put_str(s);
        emit_text();
    endtask

    task automatic put_number();
        int n;
        int pick;
        pick = $urandom_range(0, 5);
        if (pick == 0)
        begin
            n = $urandom_range(1, 3);
            repeat (n)
            begin
                pick = $urandom_range(0, 5);
                put_byte(pick == 0 ? CH_SPACE : 8'(CH_TAB + pick - 1));
            end
        end
        pick = $urandom_range(0, 7);
        if (pick == 0)
            put_byte(CH_PLUS);
        else if (pick == 1)
            put_byte(CH_MINUS);
        pick = $urandom_range(0, 11);
        if (pick == 1)
        begin
            // right at the 64-bit boundary
            put_str("1844674407370955161");
            put_byte(8'(CH_ZERO + $urandom_range(0, 9)));
        end
        else if (pick != 0)
        begin
            n = (pick == 2) ? $urandom_range(19, 22) : $urandom_range(1, 6);
            repeat (n) put_byte(8'(CH_ZERO + $urandom_range(0, 9)));
        end
        if ($urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 3);
            repeat (n) put_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic rand_text();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 12)
        begin
            n = $urandom_range(1, 24);
            repeat (n) put_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            put_str("ipn:");
            if ($urandom_range(0, 19) == 0)
                txt_q[$urandom_range(0, 3)] = 8'($urandom_range(0, 255));
            put_number();
            if ($urandom_range(0, 29) == 0)
                put_byte(CH_NUL);
            if ($urandom_range(0, 24) != 0)
                put_byte(CH_DOT);
            put_number();
            if ($urandom_range(0, 5) == 0)
            begin
                put_byte(CH_NUL);
                n = $urandom_range(0, 4);
                repeat (n) put_byte(8'($urandom_range(0, 255)));
            end
            if (kind >= 97)
            begin
                n = $urandom_range(MAX_LEN - 8, MAX_LEN + 12);
                while (txt_q.size() < n)
                    put_byte(8'($urandom_range(0, 255)));
            end
            else if (kind >= 89)
            begin
                n = $urandom_range(1, txt_q.size());
                while (txt_q.size() > n)
                    void'(txt_q.pop_back());
            end
        end
        emit_text();
    endtask

    // wait until every character is sent and every result is back
    task automatic drain();
        while (char_q.size() != 0 || chr_valid || eid_results_q.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        clear_parse();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_str("ipn:1.2");
        send_str("ipn:0.0");
        send_str("ipn:18446744073709551615.18446744073709551615");
        send_str("ipn:18446744073709551616.1");
        send_str("ipn:1.99999999999999999999");
        send_str("ipn:-1.+5");
        send_str("ipn:-0.-18446744073709551615");
        put_str("ipn:");
        put_byte(CH_SPACE);
        for (logic [7:0] b = CH_TAB; b <= CH_CR; b++)
            put_byte(b);
        put_str("7.  -0x");
        emit_text();
        send_str("ipn:12abc.34xyz");
        send_str("ipn:+ 5.6");          // sign then blank
        send_str("ipn:5.- 6");
        send_str("ipn:");
        send_str("i");
        send_str("ipx:1.2");
        send_str("IPN:1.2");
        send_str("ipn:123");
        put_str("ipn:12");              // NUL ahead of the dot
        put_byte(CH_NUL);
        put_str(".3");
        emit_text();
        put_str("ipn:1.2");             // NUL closes the service field
        put_byte(CH_NUL);
        put_str("zz");
        emit_text();
        put_str("ipn:1.");
        put_byte(CH_NUL);
        put_str("5xx");
        emit_text();
        put_str("ipn:1.2");             // exactly the longest allowed
        put_fill("x", MAX_LEN - 7);
        emit_text();
        put_str("ipn:1.2");
        put_fill("x", MAX_LEN - 6);
        emit_text();
        put_str("ipn:1.2");             // far too long
        put_fill("9", 200);
        emit_text();
        send_str("ipn:.5");
        send_str("ipn:x.x");
        send_str("abcdefgh.1");
        send_str("ab.c");
        send_str("ipn:-.5");
        send_str("ipn:5.+");
        drain();

        // receiver holds off once for a long stretch after a batch of random strings
        while (sent_chars < 900)
            rand_text();
        hold_req = 1'b1;
        drain();

        while (sent_chars < 1750)
            rand_text();
        while (char_q.size() > 200)
            @(negedge clk);
        calm = 1'b1;
        drain();
        repeat (10) @(negedge clk);

        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== ipn_endpoint_id_parser_top.f =====
+incdir+rtl
rtl/ipn_eid_pkg.sv
rtl/ipn_eid_field.sv
rtl/ipn_eid_core.sv
rtl/ipn_eid_result.sv
rtl/ipn_endpoint_id_parser_top.sv
sim/tb_ipn_endpoint_id_parser_top.sv
